### src/mce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mce_pkg: shared types and code table for the Morse encoder
// Symbol codes, the lookup entry format and the character-to-code ROM
// contents (case fold included).
// ----------------------------------------------------------------------------
package mce_pkg;

   // Result symbol codes
   localparam logic [1:0] SYM_DOT  = 2'd0;
   localparam logic [1:0] SYM_DASH = 2'd1;
   localparam logic [1:0] SYM_GAP  = 2'd2;

   // Longest dot/dash pattern and the last position of a space run
   localparam int unsigned MAX_MARKS  = 6;
   localparam logic [2:0]  SPACE_LAST = 3'd3;

   typedef enum logic [1:0] {
      KIND_MARKS,
      KIND_SPACE,
      KIND_BAD
   } kind_type;

   // Pattern: len marks, first mark in marks[5], 1 = dash
   typedef struct packed {
      logic [2:0] len;
      logic [5:0] marks;
   } code_type;

   typedef struct packed {
      kind_type kind;
      code_type code;
   } entry_type;

   // Cyrillic small letters, 0xE0..0xFF
   function automatic code_type cyr_code(input logic [4:0] idx);
      code_type c;
      unique case (idx)
         5'd0:    c = '{3'd2, 6'b010000};
         5'd1:    c = '{3'd4, 6'b100000};
         5'd2:    c = '{3'd3, 6'b011000};
         5'd3:    c = '{3'd3, 6'b110000};
         5'd4:    c = '{3'd3, 6'b100000};
         5'd5:    c = '{3'd1, 6'b000000};
         5'd6:    c = '{3'd4, 6'b000100};
         5'd7:    c = '{3'd4, 6'b110000};
         5'd8:    c = '{3'd2, 6'b000000};
         5'd9:    c = '{3'd4, 6'b011100};
         5'd10:   c = '{3'd3, 6'b101000};
         5'd11:   c = '{3'd4, 6'b010000};
         5'd12:   c = '{3'd2, 6'b110000};
         5'd13:   c = '{3'd2, 6'b100000};
         5'd14:   c = '{3'd3, 6'b111000};
         5'd15:   c = '{3'd4, 6'b011000};
         5'd16:   c = '{3'd3, 6'b010000};
         5'd17:   c = '{3'd3, 6'b000000};
         5'd18:   c = '{3'd1, 6'b100000};
         5'd19:   c = '{3'd3, 6'b001000};
         5'd20:   c = '{3'd4, 6'b001000};
         5'd21:   c = '{3'd4, 6'b000000};
         5'd22:   c = '{3'd4, 6'b101000};
         5'd23:   c = '{3'd4, 6'b111000};
         5'd24:   c = '{3'd4, 6'b111100};
         5'd25:   c = '{3'd4, 6'b110100};
         5'd26:   c = '{3'd4, 6'b100100};
         5'd27:   c = '{3'd4, 6'b101100};
         5'd28:   c = '{3'd4, 6'b100100};
         5'd29:   c = '{3'd5, 6'b001000};
         5'd30:   c = '{3'd4, 6'b001100};
         default: c = '{3'd4, 6'b010100};
      endcase
      return c;
   endfunction

   // Latin small letters a..z
   function automatic code_type lat_code(input logic [4:0] idx);
      code_type c;
      unique case (idx)
         5'd0:    c = '{3'd2, 6'b010000};
         5'd1:    c = '{3'd4, 6'b100000};
         5'd2:    c = '{3'd4, 6'b101000};
         5'd3:    c = '{3'd3, 6'b100000};
         5'd4:    c = '{3'd1, 6'b000000};
         5'd5:    c = '{3'd4, 6'b001000};
         5'd6:    c = '{3'd3, 6'b110000};
         5'd7:    c = '{3'd4, 6'b000000};
         5'd8:    c = '{3'd2, 6'b000000};
         5'd9:    c = '{3'd4, 6'b011100};
         5'd10:   c = '{3'd3, 6'b101000};
         5'd11:   c = '{3'd4, 6'b010000};
         5'd12:   c = '{3'd2, 6'b110000};
         5'd13:   c = '{3'd2, 6'b100000};
         5'd14:   c = '{3'd3, 6'b111000};
         5'd15:   c = '{3'd4, 6'b011000};
         5'd16:   c = '{3'd4, 6'b110100};
         5'd17:   c = '{3'd3, 6'b010000};
         5'd18:   c = '{3'd3, 6'b000000};
         5'd19:   c = '{3'd1, 6'b100000};
         5'd20:   c = '{3'd3, 6'b001000};
         5'd21:   c = '{3'd4, 6'b000100};
         5'd22:   c = '{3'd3, 6'b011000};
         5'd23:   c = '{3'd4, 6'b100100};
         5'd24:   c = '{3'd4, 6'b101100};
         default: c = '{3'd4, 6'b110000};
      endcase
      return c;
   endfunction

   // Digits 0..9
   function automatic code_type dig_code(input logic [3:0] idx);
      code_type c;
      unique case (idx)
         4'd0:    c = '{3'd5, 6'b111110};
         4'd1:    c = '{3'd5, 6'b011110};
         4'd2:    c = '{3'd5, 6'b001110};
         4'd3:    c = '{3'd5, 6'b000110};
         4'd4:    c = '{3'd5, 6'b000010};
         4'd5:    c = '{3'd5, 6'b000000};
         4'd6:    c = '{3'd5, 6'b100000};
         4'd7:    c = '{3'd5, 6'b110000};
         4'd8:    c = '{3'd5, 6'b111000};
         default: c = '{3'd5, 6'b111100};
      endcase
      return c;
   endfunction

   // Fold capitals to small letters
   function automatic logic [7:0] fold_case(input logic [7:0] ch);
      logic [7:0] f;
      f = ch;
      if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'hC0 && ch <= 8'hDF)) begin
         f = ch + 8'h20;
      end else if (ch == 8'hA8) begin
         f = 8'hB8;
      end
      return f;
   endfunction

   // Full ROM contents: byte in, entry out
   function automatic entry_type code_lookup(input logic [7:0] ch);
      entry_type e;
      logic [7:0] f;
      logic [7:0] lat_off;
      f       = fold_case(ch);
      lat_off = f - 8'h61;
      e       = '{KIND_MARKS, '{3'd0, 6'b000000}};
      if (f == 8'h20) begin
         e.kind = KIND_SPACE;
      end else if (f >= 8'hE0) begin
         e.code = cyr_code(f[4:0]);
      end else if (f == 8'hB8) begin
         e.code = '{3'd1, 6'b000000};
      end else if (f >= 8'h61 && f <= 8'h7A) begin
         e.code = lat_code(lat_off[4:0]);
      end else if (f >= 8'h30 && f <= 8'h39) begin
         e.code = dig_code(f[3:0]);
      end else begin
         unique case (f)
            8'h2E:        e.code = '{3'd6, 6'b000000};
            8'h2C:        e.code = '{3'd6, 6'b010101};
            8'h3A:        e.code = '{3'd6, 6'b111000};
            8'h3B:        e.code = '{3'd6, 6'b101010};
            8'h28, 8'h29: e.code = '{3'd6, 6'b101101};
            8'h2D:        e.code = '{3'd6, 6'b100001};
            8'h2F:        e.code = '{3'd5, 6'b100100};
            8'h3F:        e.code = '{3'd6, 6'b001100};
            8'h21:        e.code = '{3'd6, 6'b110011};
            8'h40:        e.code = '{3'd6, 6'b011010};
            default:      e.kind = KIND_BAD;
         endcase
      end
      return e;
   endfunction

endpackage

### src/morse_code_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_code_encoder_top: Windows-1251 character to Morse symbol stream
// Each character word is looked up in a code ROM and played out as dots and
// dashes, one symbol per result word, closed by a gap marked with tlast.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)       tuser      tlast
//  req_     in   [7:0] char_code          -          -
//  rsp_     out  [1:0] symbol, [7:2] zero [0] bad    last
//
//  A character gives 1 to 7 result words, one per cycle while rsp_tready
//  is high; the output register is the bottleneck, so the sustained rate
//  is one result word per cycle with no bubble between characters.
//  A first result passes the ROM output reg, serializer load, then output reg.
//  Reset is synchronous, active high, and empties all stages.
//  rsp_tready low freezes the output; a looked-up word waits in the ROM
//  output register and req_tready drops only when that register is full.
// ----------------------------------------------------------------------------
module morse_code_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [1:0] symbol, [7:2] zero
   output logic       rsp_tuser,   // [0] bad_char
   output logic       rsp_tlast
);

   // ROM output register (lookup result waiting for the serializer)
   logic                hold_valid_ff, hold_valid_in;
   mce_pkg::entry_type  hold_ff;

   // Entry being played out
   logic                cur_valid_ff, cur_valid_in;
   mce_pkg::entry_type  cur_ff;
   logic [2:0]          pos_ff, pos_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_sym_ff;
   logic                rsp_bad_ff;
   logic                rsp_last_ff;

   logic                out_free;
   logic                emit;
   logic                cur_done;
   logic                hold_take;
   logic                req_acc;
   logic [1:0]          sym_val;
   logic                sym_bad;
   logic                sym_last;
   logic [2:0]          mark_idx;

   // Symbol for the current position
   assign mark_idx = 3'd5 - pos_ff;

   always_comb begin
      sym_val  = mce_pkg::SYM_DOT;
      sym_bad  = 1'b0;
      sym_last = 1'b0;
      unique case (cur_ff.kind)
         mce_pkg::KIND_MARKS: begin
            if (pos_ff < cur_ff.code.len) begin
               sym_val = cur_ff.code.marks[mark_idx] ? mce_pkg::SYM_DASH
                                                     : mce_pkg::SYM_DOT;
            end else begin
               sym_val  = mce_pkg::SYM_GAP;
               sym_last = 1'b1;
            end
         end
         mce_pkg::KIND_SPACE: begin
            sym_val  = mce_pkg::SYM_GAP;
            sym_last = (pos_ff == mce_pkg::SPACE_LAST);
         end
         default: begin
            sym_bad  = 1'b1;
            sym_last = 1'b1;
         end
      endcase
   end

   // Handshake and stage movement
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit       = cur_valid_ff && out_free;
   assign cur_done   = emit && sym_last;
   assign hold_take  = hold_valid_ff && (!cur_valid_ff || cur_done);
   assign req_tready = !hold_valid_ff || hold_take;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      hold_valid_in = req_acc ? 1'b1 : (hold_take ? 1'b0 : hold_valid_ff);
      cur_valid_in  = hold_take ? 1'b1 : (cur_done ? 1'b0 : cur_valid_ff);
      pos_in        = hold_take ? 3'd0 : (emit ? pos_ff + 3'd1 : pos_ff);
      rsp_valid_in  = emit ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         cur_valid_ff  <= 1'b0;
         pos_ff        <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         cur_valid_ff  <= cur_valid_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Code ROM read (registered) and payload stages
   always_ff @(posedge clock) begin
      if (req_acc) begin
         hold_ff <= mce_pkg::code_lookup(req_tdata);
      end
      if (hold_take) begin
         cur_ff <= hold_ff;
      end
      if (emit) begin
         rsp_sym_ff  <= sym_val;
         rsp_bad_ff  <= sym_bad;
         rsp_last_ff <= sym_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_sym_ff};
   assign rsp_tuser  = rsp_bad_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   a_bad_is_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata[1:0] == mce_pkg::SYM_DOT)
      else $error("bad_char result not a lone dot word");

   a_hold_no_overrun: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && !hold_take |-> !req_tready)
      else $error("ROM output register overwritten while full");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff && cur_ff.kind == mce_pkg::KIND_MARKS |-> pos_ff <= cur_ff.code.len)
      else $error("position ran past the pattern");

   a_space_len: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff && cur_ff.kind == mce_pkg::KIND_SPACE |-> pos_ff <= mce_pkg::SPACE_LAST)
      else $error("space run too long");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

endmodule

### dv/morse_code_encoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_code_encoder_top_tb: self-checking bench for the Morse encoder
// Feeds Windows-1251 character words (a directed set of edge characters,
// then a random mix that leans on valid letters, digits, marks and spaces),
// predicts each character's symbol words and checks every result word in
// order. Both sides idle and stall at random; some characters wait for a drain.
// ----------------------------------------------------------------------------
module morse_code_encoder_top_tb;

   localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no handshake
   localparam int unsigned TAIL_CYCLES = 20;    // settle time after last word
   localparam int unsigned RANDOM_CHARS = 185;

   // One character waiting to be sent, with its lead-in idle time
   typedef struct {
      logic [7:0]  ch;
      int unsigned gap;
      bit          drain;   // hold off until every symbol is back
   } char_job_type;

   // One expected symbol word
   typedef struct {
      logic [7:0] ch;
      logic [1:0] symbol;
      logic       bad_char;
      logic       last;
   } morse_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;

   char_job_type   char_q[$];
   morse_word_type symbol_q[$];
   bit             symbols_settled;
   int unsigned    err_count = 0;
   int unsigned    result_idx = 0;
   int unsigned    quiet_cycles;
   int unsigned    hold_off;
   bit             head_armed;
   int unsigned    stall_left;
   int unsigned    rx_calm;
   int unsigned    draw;
   morse_word_type got;

   // Morse patterns: small Cyrillic from 0xE0, Latin from 'a', digits
   string cyr_pat [32] = '{
      ".-", "-...", ".--", "--.", "-..", ".", "...-", "--..",
      "..", ".---", "-.-", ".-..", "--", "-.", "---", ".--.",
      ".-.", "...", "-", "..-", "..-.", "....", "-.-.", "---.",
      "----", "--.-", "-..-", "-.--", "-..-", "..-..", "..--", ".-.-"
   };
   string lat_pat [26] = '{
      ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....",
      "..", ".---", "-.-", ".-..", "--", "-.", "---", ".--.",
      "--.-", ".-.", "...", "-", "..-", "...-", ".--", "-..-",
      "-.--", "--.."
   };
   string dig_pat [10] = '{
      "-----", ".----", "..---", "...--", "....-",
      ".....", "-....", "--...", "---..", "----."
   };

   // Punctuation that has a code: . , : ; ( ) - / ? ! @
   logic [7:0] punct_set [11] = '{
      8'h2E, 8'h2C, 8'h3A, 8'h3B, 8'h28, 8'h29, 8'h2D, 8'h2F, 8'h3F, 8'h21, 8'h40
   };

   morse_code_encoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   task automatic note_error(input string msg);
      err_count++;
      if (err_count <= 10) begin
         $display("ERROR: %s", msg);
      end
   endtask

   // Capitals to small: Latin A..Z, Cyrillic 0xC0..0xDF, IO 0xA8
   function automatic logic [7:0] lower_1251(input logic [7:0] ch);
      if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'hC0 && ch <= 8'hDF)) begin
         return ch + 8'h20;
      end
      if (ch == 8'hA8) begin
         return 8'hB8;
      end
      return ch;
   endfunction

   // Dot/dash string of a folded character; empty when it has no code
   function automatic string morse_of(input logic [7:0] f);
      logic [7:0] cyr_off;
      logic [7:0] lat_off;
      logic [7:0] dig_off;
      cyr_off = f - 8'hE0;
      lat_off = f - 8'h61;
      dig_off = f - 8'h30;
      if (f >= 8'hE0) return cyr_pat[cyr_off[4:0]];
      if (f == 8'hB8) return ".";             // small io sounds as ie
      if (f >= 8'h61 && f <= 8'h7A) return lat_pat[lat_off[4:0]];
      if (f >= 8'h30 && f <= 8'h39) return dig_pat[dig_off[3:0]];
      case (f)
         8'h2E:        return "......";
         8'h2C:        return ".-.-.-";
         8'h3A:        return "---...";
         8'h3B:        return "-.-.-.";
         8'h28, 8'h29: return "-.--.-";
         8'h2D:        return "-....-";
         8'h2F:        return "-..-.";
         8'h3F:        return "..--..";
         8'h21:        return "--..--";
         8'h40:        return ".--.-.";
         default:      return "";
      endcase
   endfunction

   // Queue up the symbol words one character should produce
   task automatic push_symbols(input logic [7:0] ch);
      logic [7:0]     f;
      string          pat;
      morse_word_type w;
      f          = lower_1251(ch);
      pat        = morse_of(f);
      w.ch       = ch;
      w.bad_char = 1'b0;
      w.last     = 1'b0;
      if (f == 8'h20) begin
         // word space: three gaps plus the closing gap
         w.symbol = mce_pkg::SYM_GAP;
         repeat (3) symbol_q.push_back(w);
         w.last = 1'b1;
         symbol_q.push_back(w);
      end else if (pat.len() == 0) begin
         w.symbol   = mce_pkg::SYM_DOT;
         w.bad_char = 1'b1;
         w.last     = 1'b1;
         symbol_q.push_back(w);
      end else begin
         for (int i = 0; i < pat.len(); i++) begin
            w.symbol = (pat[i] == "-") ? mce_pkg::SYM_DASH : mce_pkg::SYM_DOT;
            symbol_q.push_back(w);
         end
         w.symbol = mce_pkg::SYM_GAP;
         w.last   = 1'b1;
         symbol_q.push_back(w);
      end
   endtask

   // Sender: one character word per job, after its idle gap
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         head_armed = 1'b0;
         hold_off   = 0;
      end else if (!req_tvalid || req_tready) begin
         if (char_q.size() != 0 && !head_armed) begin
            hold_off   = char_q[0].gap;
            head_armed = 1'b1;
         end
         if (char_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (hold_off != 0) begin
            hold_off--;
            req_tvalid <= 1'b0;
         end else if (char_q[0].drain && (req_tvalid || !symbols_settled)) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tdata  <= char_q[0].ch;
            req_tvalid <= 1'b1;
            void'(char_q.pop_front());
            head_armed = 1'b0;
         end
      end
   end

   // Receiver: random stall after each word, with calm stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         rx_calm    = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (rx_calm != 0) begin
            rx_calm--;
            draw = 0;
         end else if ($urandom_range(0, 7) == 0) begin
            rx_calm = $urandom_range(10, 40);
            draw    = 0;
         end else begin
            draw = $urandom_range(0, 19);
         end
         if (draw == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left = draw - 1;
         end
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on accepted characters, check result words in order
   always @(posedge clock) begin
      if (reset) begin
         symbols_settled <= 1'b1;
      end else begin
         if (req_tvalid && req_tready) begin
            push_symbols(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (symbol_q.size() == 0) begin
               note_error($sformatf("unexpected word: tdata %02h tuser %0b tlast %0b",
                                    rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               got = symbol_q.pop_front();
               if (rsp_tdata !== {6'd0, got.symbol} || rsp_tuser !== got.bad_char ||
                   rsp_tlast !== got.last) begin
                  note_error($sformatf(
                     "word %0d char %02h: exp tdata %02h tuser %0b tlast %0b, got %02h %0b %0b",
                     result_idx, got.ch, {6'd0, got.symbol}, got.bad_char, got.last,
                     rsp_tdata, rsp_tuser, rsp_tlast));
               end
            end
            result_idx++;
         end
         symbols_settled <= (symbol_q.size() == 0);
      end
   end

   // Watchdog on handshake activity
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus and end of test
   initial begin
      logic [7:0]   edge_chars [25];
      char_job_type job;
      int unsigned  pick;
      int unsigned  tx_calm;
      logic [3:0]   punct_idx;

      // edge characters: byte extremes, space, letter ranges, both case
      // folds, hard and soft sign, io, marks, digits, unknown bytes
      edge_chars = '{8'h00, 8'hFF, 8'h20, 8'h41, 8'h5A, 8'h61, 8'h7A, 8'hC0, 8'hDF,
                     8'hE0, 8'hFA, 8'hFC, 8'hA8, 8'hB8, 8'h2E, 8'h2C, 8'h3B, 8'h2D,
                     8'h28, 8'h29, 8'h40, 8'h30, 8'h39, 8'h80, 8'h7F};
      tx_calm = 0;
      foreach (edge_chars[i]) begin
         job.ch    = edge_chars[i];
         job.gap   = (i < 12) ? 0 : $urandom_range(0, 19);
         job.drain = 1'b0;
         char_q.push_back(job);
      end

      for (int n = 0; n < RANDOM_CHARS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 24) begin
            job.ch = 8'(8'hC0 + $urandom_range(0, 63));
         end else if (pick < 40) begin
            job.ch = 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25));
         end else if (pick < 52) begin
            job.ch = 8'(8'h30 + $urandom_range(0, 9));
         end else if (pick < 64) begin
            punct_idx = 4'($urandom_range(0, 10));
            job.ch    = punct_set[punct_idx];
         end else if (pick < 72) begin
            job.ch = 8'h20;
         end else if (pick < 78) begin
            job.ch = $urandom_range(0, 1) ? 8'hA8 : 8'hB8;
         end else begin
            job.ch = 8'($urandom_range(0, 255));
         end
         if (tx_calm != 0) begin
            tx_calm--;
            job.gap = 0;
         end else if ($urandom_range(0, 7) == 0) begin
            tx_calm = $urandom_range(10, 30);
            job.gap = 0;
         end else begin
            job.gap = $urandom_range(0, 19);
         end
         job.drain = (n == 0) || ($urandom_range(0, 39) == 0);
         char_q.push_back(job);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (char_q.size() != 0 || req_tvalid || symbol_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (symbol_q.size() != 0) begin
         note_error($sformatf("%0d expected words never arrived", symbol_q.size()));
      end

      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
